[design/rgmt_pkg.sv]
// shared types and constants of the raster grid mask triangulation unit
package rgmt_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int POS_W       = 10;
	localparam int IDX_W       = 20;
	localparam int COL_AW      = $clog2(MAX_COLUMNS);
	localparam int SLOT_W      = IDX_W + 1;
	localparam int IN_W        = 8;
	localparam int OUT_W       = 104;
	localparam int MAX_RES     = 3;

	localparam logic [POS_W-1:0] GRID_WIDTH_RESET  = POS_W'(1023);
	localparam logic [POS_W-1:0] GRID_HEIGHT_RESET = POS_W'(1023);

	typedef enum logic {
		CFG_GRID_WIDTH  = 1'b0,
		CFG_GRID_HEIGHT = 1'b1
	} cfg_index_t;

	typedef enum logic {
		KIND_NODE     = 1'b0,
		KIND_TRIANGLE = 1'b1
	} kind_t;

	// node slot: valid flag and node index
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
	} slot_t;

	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] node_index;
		logic [POS_W-1:0] node_column;
		logic [POS_W-1:0] node_row;
		logic             on_boundary;
		logic [IDX_W-1:0] corner_one;
		logic [IDX_W-1:0] corner_two;
		logic [IDX_W-1:0] corner_three;
	} result_t;

	function automatic result_t make_tri(slot_t p, slot_t q, slot_t r);
		result_t t;
		t              = '0;
		t.kind         = KIND_TRIANGLE;
		t.corner_one   = p.idx;
		t.corner_two   = q.idx;
		t.corner_three = r.idx;
		return t;
	endfunction

endpackage

[design/rgmt_ram.sv]
// generic single-write, single-read ram with registered read data
module rgmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/raster_grid_mask_triangulation_unit.sv]
// raster grid mask triangulation: node numbering and quad-split triangles
// path: a point is registered in stage 1 with its row store read, then in the result buffer
// throughput with m_tready high: one point per cycle if it yields at most one result,
// else one per result, as the single result buffer drains one result per cycle
// reset: counters, positions, left and upper-left slots clear; registers return to 1023
// the row store ram is not cleared; each row overwrites what the next row reads
module raster_grid_mask_triangulation_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [rgmt_pkg::IN_W-1:0]            s_tdata,   // inside_flag, boundary_flag
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// node_index, node_column, node_row, on_boundary, corner_one, corner_two, corner_three
	output logic [rgmt_pkg::OUT_W-1:0]           m_tdata,
	output logic                                 m_tuser,   // kind
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [rgmt_pkg::POS_W-1:0]           cfg_data
);

	// configuration
	logic [rgmt_pkg::POS_W-1:0] grid_width_q;
	logic [rgmt_pkg::POS_W-1:0] grid_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= rgmt_pkg::GRID_WIDTH_RESET;
			grid_height_q <= rgmt_pkg::GRID_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (rgmt_pkg::cfg_index_t'(cfg_index))
				rgmt_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				rgmt_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage state
	logic [rgmt_pkg::POS_W-1:0] col_q;
	logic [rgmt_pkg::POS_W-1:0] row_q;
	logic [rgmt_pkg::IDX_W-1:0] cnt_q;
	rgmt_pkg::slot_t            left_q;

	// stage 1
	logic                        s1_valid_q;
	logic [rgmt_pkg::POS_W-1:0]  col_s1;
	logic [rgmt_pkg::POS_W-1:0]  row_s1;
	logic                        bnd_s1;
	logic                        end_s1;
	logic                        fwd_s1;
	rgmt_pkg::slot_t             fwd_data_s1;
	rgmt_pkg::slot_t             cur_s1;
	rgmt_pkg::slot_t             d_s1;
	rgmt_pkg::slot_t             ul_q;

	// result buffer
	logic                        s2_valid_q;
	rgmt_pkg::result_t           buf_q [rgmt_pkg::MAX_RES];
	logic [1:0]                  n_q;
	logic [1:0]                  ptr_q;

	logic                        accept;
	logic                        s1_adv;
	logic                        s2_free;
	logic                        out_xfer;
	logic                        out_final;
	logic                        point_in;
	logic                        row_end;
	logic                        grid_end;
	rgmt_pkg::slot_t             cur;
	logic [rgmt_pkg::SLOT_W-1:0] ram_rdata;
	rgmt_pkg::slot_t             above;

	rgmt_pkg::result_t           ent [rgmt_pkg::MAX_RES];
	logic [1:0]                  n_new;

	assign out_xfer  = m_tvalid && m_tready;
	assign out_final = out_xfer && (ptr_q == n_q - 2'd1);
	assign s2_free   = !s2_valid_q || out_final;
	assign s1_adv    = !s1_valid_q || s2_free;
	assign s_tready  = s1_adv;
	assign accept    = s_tvalid && s_tready;

	assign point_in  = s_tdata[0] || s_tdata[1];
	assign cur.valid = point_in;
	assign cur.idx   = cnt_q;
	assign row_end   = col_q >= grid_width_q;
	assign grid_end  = row_end && (row_q >= grid_height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cnt_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q  <= '0;
				left_q <= '0;
				if (grid_end) begin
					row_q <= '0;
					cnt_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					cnt_q <= cnt_q + rgmt_pkg::IDX_W'(point_in);
				end
			end else begin
				col_q  <= col_q + 1'b1;
				left_q <= cur;
				cnt_q  <= cnt_q + rgmt_pkg::IDX_W'(point_in);
			end
		end
	end

	// row store: read at transfer, written back when the point leaves stage 1
	rgmt_ram #(
		.WIDTH(rgmt_pkg::SLOT_W),
		.DEPTH(rgmt_pkg::MAX_COLUMNS)
	) u_row_store (
		.clk  (clk),
		.we   (s1_valid_q && s1_adv),
		.waddr(col_s1[rgmt_pkg::COL_AW-1:0]),
		.wdata(cur_s1),
		.re   (accept),
		.raddr(col_q[rgmt_pkg::COL_AW-1:0]),
		.rdata(ram_rdata)
	);

	// same column read while it is written back: take the value in flight
	assign above = fwd_s1 ? fwd_data_s1 : rgmt_pkg::slot_t'(ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			ul_q       <= '0;
		end else if (s1_adv) begin
			s1_valid_q <= accept;
			if (s1_valid_q) begin
				ul_q <= end_s1 ? '0 : above;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_q;
			row_s1      <= row_q;
			bnd_s1      <= s_tdata[1];
			end_s1      <= row_end;
			cur_s1      <= cur;
			d_s1        <= left_q;
			fwd_s1      <= s1_valid_q && (col_s1 == col_q);
			fwd_data_s1 <= cur_s1;
		end
	end

	// quad-split rule and result list
	always_comb begin
		rgmt_pkg::slot_t   a;
		rgmt_pkg::slot_t   b;
		rgmt_pkg::slot_t   c;
		rgmt_pkg::slot_t   d;
		logic              en;
		logic              t_abc;
		logic              t_acd;
		logic              t_abd;
		logic              t_bcd;
		rgmt_pkg::result_t node;
		rgmt_pkg::result_t tri_a;
		rgmt_pkg::result_t tri_b;
		logic [1:0]        ntri;

		a  = ul_q;
		b  = above;
		c  = cur_s1;
		d  = d_s1;
		en = (col_s1 != '0) && (row_s1 != '0);

		t_abc = en && a.valid && c.valid && b.valid;
		t_acd = en && a.valid && c.valid && d.valid;
		t_abd = en && a.valid && !c.valid && b.valid && d.valid;
		t_bcd = en && !a.valid && b.valid && c.valid && d.valid;

		node             = '0;
		node.kind        = rgmt_pkg::KIND_NODE;
		node.node_index  = c.idx;
		node.node_column = col_s1;
		node.node_row    = row_s1;
		node.on_boundary = bnd_s1;

		if (t_abc) begin
			tri_a = rgmt_pkg::make_tri(a, b, c);
		end else if (t_acd) begin
			tri_a = rgmt_pkg::make_tri(a, c, d);
		end else if (t_abd) begin
			tri_a = rgmt_pkg::make_tri(a, b, d);
		end else begin
			tri_a = rgmt_pkg::make_tri(b, c, d);
		end
		tri_b = rgmt_pkg::make_tri(a, c, d);
		ntri  = 2'(t_abc) + 2'(t_acd) + 2'(t_abd) + 2'(t_bcd);

		if (c.valid) begin
			ent[0] = node;
			ent[1] = tri_a;
			ent[2] = tri_b;
		end else begin
			ent[0] = tri_a;
			ent[1] = tri_b;
			ent[2] = tri_b;
		end
		n_new = ntri + 2'(c.valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			n_q        <= '0;
			ptr_q      <= '0;
		end else if (s1_valid_q && s2_free) begin
			s2_valid_q <= n_new != 2'd0;
			n_q        <= n_new;
			ptr_q      <= '0;
		end else if (out_final) begin
			s2_valid_q <= 1'b0;
		end else if (out_xfer) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && s2_free) begin
			buf_q <= ent;
		end
	end

	always_comb begin
		rgmt_pkg::result_t r;
		case (ptr_q)
			2'd0:    r = buf_q[0];
			2'd1:    r = buf_q[1];
			default: r = buf_q[2];
		endcase
		m_tuser = r.kind;
		m_tdata = {3'b000, r.corner_three, r.corner_two, r.corner_one, r.on_boundary,
			r.node_row, r.node_column, r.node_index};
	end

	assign m_tvalid = s2_valid_q;
	assign m_tlast  = ptr_q == n_q - 2'd1;

endmodule
